// ----- hw/rtl/pcpa_pkg.sv -----
// Package for the per-core page allocator: sizes, status codes and state type.
// No dependencies.
`default_nettype none
package pcpa_pkg;
    localparam int NUM_CORES  = 8;
    localparam int PAGE_COUNT = 32768;
    localparam int PAGE_SHIFT = 12;

    localparam int ADDR_W  = 34;
    localparam int END_W   = 35;
    localparam int HC_W    = 6;
    localparam int CORE_IN_W = 6;
    localparam int CORE_W  = (NUM_CORES > 1) ? $clog2(NUM_CORES) : 1;
    localparam int SCAN_W  = HC_W + 1;
    localparam int IDX_W   = (PAGE_COUNT > 1) ? $clog2(PAGE_COUNT) : 1;
    localparam int COUNT_W = 16;
    localparam int DIVR_W  = HC_W + 1;
    localparam int DCNT_W  = $clog2(COUNT_W);
    localparam int CFG_W   = 2;

    // status codes
    localparam logic [1:0] STAT_ALLOC = 2'd0;
    localparam logic [1:0] STAT_FREED = 2'd1;
    localparam logic [1:0] STAT_EMPTY = 2'd2;
    localparam logic [1:0] STAT_BAD   = 2'd3;

    // register indexes
    localparam logic [CFG_W-1:0] REG_HIGHEST_CORE = 2'd0;
    localparam logic [CFG_W-1:0] REG_REGION_START = 2'd1;
    localparam logic [CFG_W-1:0] REG_REGION_END   = 2'd2;

    // opcodes
    localparam logic OP_FREE  = 1'b0;
    localparam logic OP_ALLOC = 1'b1;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_DECODE,
        ST_POP,
        ST_SCAN,
        ST_DIV,
        ST_WALK_RD,
        ST_WALK_WT,
        ST_RESP
    } t_state;
endpackage
`default_nettype wire

// ----- hw/rtl/pcpa_ram.sv -----
// Generic single-port-write, single-read RAM with registered read data.
// No dependencies.
`default_nettype none
module pcpa_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  wire                     i_clk,
    input  wire                     i_we,
    input  wire [$clog2(DEPTH)-1:0] i_waddr,
    input  wire [WIDTH-1:0]         i_wdata,
    input  wire [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]        o_rdata
);
    logic [WIDTH-1:0] r_mem [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        o_rdata <= r_mem[i_raddr];
    end
endmodule
`default_nettype wire

// ----- hw/rtl/per_core_page_allocator.sv -----
// Top level of the per-core page allocator: control sequencer, list heads and counts.
// Depends on pcpa_pkg and pcpa_ram (the shared next-link memory).
//
// One item is handled at a time, and the input takes a transfer only in the idle state.
// A free passes through decode, response and the output register, and the next transfer
// can be taken once it has left the response state. An allocate from a non-empty local
// list adds a pop step, because the pop takes the registered read of the link memory
// issued in decode. An allocate that must steal replaces the pop step
// with several steps:
//   - a scan step per core scanned, up to and including the victim;
//   - a bit-serial division of the victim's count by highest_core+1;
//   - a read and a wait step per stolen page, walking links through the single read port.
// When no core has pages, the scan covers cores 0..min(highest_core, NUM_CORES-1) plus
// a closing step, and reports out of pages. The result sits in an output register,
// so the next transfer is taken while it waits. A result that is still waiting holds the
// following item in its response state. Never-written link entries are not initialized.
`default_nettype none
module per_core_page_allocator (
    input  wire         i_clk,
    input  wire         i_rst_n,
    // configuration write port
    input  wire         i_cfg_wen,
    input  wire [1:0]   i_cfg_addr,
    input  wire [34:0]  i_cfg_wdata,
    // input stream
    input  wire         s_axis_tvalid,
    output logic        s_axis_tready,
    input  wire [39:0]  s_axis_tdata,   // [5:0] core, [39:6] page_address
    input  wire         s_axis_tuser,   // [0] opcode
    // result stream
    output logic        m_axis_tvalid,
    input  wire         m_axis_tready,
    output logic [39:0] m_axis_tdata,   // [33:0] granted_address, [39:34] zero
    output logic [1:0]  m_axis_tuser    // [1:0] status
);
    import pcpa_pkg::*;

    localparam logic [COUNT_W-1:0] CNT_MAX = '1;
    localparam logic [END_W-1:0]   PG_MASK = END_W'((64'd1 << PAGE_SHIFT) - 1);

    t_state r_state, n_state;

    // configuration
    logic [HC_W-1:0]   r_hc;
    logic [ADDR_W-1:0] r_rstart;
    logic [END_W-1:0]  r_rend;

    // per-core list state
    logic [IDX_W-1:0]   r_head  [NUM_CORES];
    logic [COUNT_W-1:0] r_count [NUM_CORES];

    // item registers
    logic                 r_op;
    logic [CORE_IN_W-1:0] r_core;
    logic [ADDR_W-1:0]    r_addr;

    // work registers
    logic [SCAN_W-1:0]  r_scan;
    logic [CORE_W-1:0]  r_victim;
    logic [COUNT_W-1:0] r_quo;
    logic [DIVR_W-1:0]  r_rem;
    logic [DCNT_W-1:0]  r_dcnt;
    logic [COUNT_W-1:0] r_n;
    logic [COUNT_W-1:0] r_k;
    logic [IDX_W-1:0]   r_tail;
    logic [IDX_W-1:0]   r_second;
    logic [IDX_W-1:0]   r_grant;
    logic [1:0]         r_res;

    // output register
    logic              r_out_valid;
    logic [ADDR_W-1:0] r_out_addr;
    logic [1:0]        r_out_status;

    // link memory port
    logic             ram_we;
    logic [IDX_W-1:0] ram_waddr;
    logic [IDX_W-1:0] ram_wdata;
    logic [IDX_W-1:0] ram_raddr;
    logic [IDX_W-1:0] ram_rdata;

    pcpa_ram #(.WIDTH(IDX_W), .DEPTH(PAGE_COUNT)) u_link (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_waddr (ram_waddr),
        .i_wdata (ram_wdata),
        .i_raddr (ram_raddr),
        .o_rdata (ram_rdata)
    );

    // derived values
    logic [END_W-1:0]   base;
    logic [END_W-1:0]   rel;
    logic               core_ok;
    logic [CORE_W-1:0]  cidx;
    logic [CORE_W-1:0]  sidx;
    logic [HC_W-1:0]    limit;
    logic               free_ok;
    logic [DIVR_W-1:0]  divisor;
    logic [DIVR_W:0]    rem_sh;
    logic               div_ge;
    logic               s_accept;
    logic               out_free;

    assign base    = ({1'b0, r_rstart} + PG_MASK) & ~PG_MASK;
    assign rel     = {1'b0, r_addr} - base;
    assign core_ok = r_core < CORE_IN_W'(NUM_CORES);
    assign cidx    = r_core[CORE_W-1:0];
    assign sidx    = r_scan[CORE_W-1:0];
    assign limit   = (r_hc > HC_W'(NUM_CORES - 1)) ? HC_W'(NUM_CORES - 1) : r_hc;
    assign divisor = {1'b0, r_hc} + DIVR_W'(1);
    assign rem_sh  = {r_rem, r_quo[COUNT_W-1]};
    assign div_ge  = rem_sh >= {1'b0, divisor};

    // free checks: core range, alignment, region bounds, page index range
    assign free_ok = core_ok
                  && ((({1'b0, r_addr}) & PG_MASK) == '0)
                  && (r_addr >= r_rstart)
                  && ({1'b0, r_addr} < r_rend)
                  && ({1'b0, r_addr} >= base)
                  && ((rel >> PAGE_SHIFT) < END_W'(PAGE_COUNT));

    assign s_accept  = s_axis_tvalid && s_axis_tready;
    assign out_free  = !r_out_valid || m_axis_tready;
    assign s_axis_tready = (r_state == ST_IDLE);
    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tdata  = {6'd0, r_out_addr};
    assign m_axis_tuser  = r_out_status;

    // next state
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            ST_IDLE: begin
                if (s_accept) n_state = ST_DECODE;
            end
            ST_DECODE: begin
                if (r_op == OP_ALLOC && core_ok && r_count[cidx] != '0) begin
                    n_state = ST_POP;
                end else if (r_op == OP_ALLOC && core_ok) begin
                    n_state = ST_SCAN;
                end else begin
                    n_state = ST_RESP;
                end
            end
            ST_POP: n_state = ST_RESP;
            ST_SCAN: begin
                if (r_scan > {1'b0, limit}) begin
                    n_state = ST_RESP;
                end else if (sidx != cidx && r_count[sidx] != '0) begin
                    n_state = ST_DIV;
                end
            end
            ST_DIV: begin
                if (r_dcnt == '0) n_state = ST_WALK_RD;
            end
            ST_WALK_RD: n_state = ST_WALK_WT;
            ST_WALK_WT: n_state = (r_k < r_n) ? ST_WALK_RD : ST_RESP;
            ST_RESP: begin
                if (out_free) n_state = ST_IDLE;
            end
            default: n_state = ST_IDLE;
        endcase
    end

    // link memory access
    always_comb begin
        ram_we    = 1'b0;
        ram_waddr = rel[PAGE_SHIFT +: IDX_W];
        ram_wdata = r_head[cidx];
        ram_raddr = r_tail;
        unique case (r_state)
            ST_DECODE: begin
                ram_we    = (r_op == OP_FREE) && free_ok;
                ram_raddr = r_head[cidx];
            end
            default: ram_raddr = r_tail;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_IDLE;
            r_hc        <= '0;
            r_rstart    <= '0;
            r_rend      <= '0;
            r_out_valid <= 1'b0;
            for (int i = 0; i < NUM_CORES; i++) begin
                r_head[i]  <= '0;
                r_count[i] <= '0;
            end
        end else begin
            r_state <= n_state;

            // configuration writes
            if (i_cfg_wen) begin
                unique case (i_cfg_addr)
                    REG_HIGHEST_CORE: r_hc     <= i_cfg_wdata[HC_W-1:0];
                    REG_REGION_START: r_rstart <= i_cfg_wdata[ADDR_W-1:0];
                    REG_REGION_END:   r_rend   <= i_cfg_wdata;
                    default: ;
                endcase
            end

            // output register: load on response, clear on transfer
            if (r_state == ST_RESP && out_free) begin
                r_out_valid <= 1'b1;
            end else if (m_axis_tready) begin
                r_out_valid <= 1'b0;
            end

            unique case (r_state)
                ST_IDLE: begin
                    if (s_accept) begin
                        r_op   <= s_axis_tuser;
                        r_core <= s_axis_tdata[CORE_IN_W-1:0];
                        r_addr <= s_axis_tdata[CORE_IN_W +: ADDR_W];
                    end
                end
                ST_DECODE: begin
                    r_scan <= '0;
                    r_tail <= r_head[cidx];
                    if (r_op == OP_FREE) begin
                        r_res <= free_ok ? STAT_FREED : STAT_BAD;
                        if (free_ok) begin
                            r_head[cidx] <= rel[PAGE_SHIFT +: IDX_W];
                            if (r_count[cidx] != CNT_MAX) begin
                                r_count[cidx] <= r_count[cidx] + COUNT_W'(1);
                            end
                        end
                    end else begin
                        r_res   <= STAT_EMPTY;
                        r_grant <= r_head[cidx];
                    end
                end
                ST_POP: begin
                    // pop the local head
                    r_head[cidx]  <= ram_rdata;
                    r_count[cidx] <= r_count[cidx] - COUNT_W'(1);
                    r_res         <= STAT_ALLOC;
                end
                ST_SCAN: begin
                    r_victim <= sidx;
                    r_quo    <= r_count[sidx];
                    r_rem    <= '0;
                    r_dcnt   <= DCNT_W'(COUNT_W - 1);
                    r_grant  <= r_head[sidx];
                    r_tail   <= r_head[sidx];
                    r_k      <= COUNT_W'(1);
                    r_scan   <= r_scan + SCAN_W'(1);
                end
                ST_DIV: begin
                    // one quotient bit per cycle
                    r_rem  <= div_ge ? DIVR_W'(rem_sh - {1'b0, divisor})
                                     : rem_sh[DIVR_W-1:0];
                    r_quo  <= {r_quo[COUNT_W-2:0], div_ge};
                    r_dcnt <= r_dcnt - DCNT_W'(1);
                    if (r_dcnt == '0) begin
                        r_n <= ({r_quo[COUNT_W-2:0], div_ge} == '0) ? COUNT_W'(1)
                                : {r_quo[COUNT_W-2:0], div_ge};
                    end
                end
                ST_WALK_RD: ;
                ST_WALK_WT: begin
                    if (r_k == COUNT_W'(1)) r_second <= ram_rdata;
                    if (r_k < r_n) begin
                        r_tail <= ram_rdata;
                        r_k    <= r_k + COUNT_W'(1);
                    end else begin
                        // detach the stolen run, hand the rest to the caller
                        r_head[r_victim]  <= ram_rdata;
                        r_count[r_victim] <= r_count[r_victim] - r_n;
                        if (r_n > COUNT_W'(1)) begin
                            r_head[cidx]  <= (r_k == COUNT_W'(1)) ? ram_rdata : r_second;
                            r_count[cidx] <= r_n - COUNT_W'(1);
                        end
                        r_res <= STAT_ALLOC;
                    end
                end
                ST_RESP: begin
                    if (out_free) begin
                        r_out_status <= r_res;
                        r_out_addr   <= (r_res == STAT_ALLOC)
                            ? base[ADDR_W-1:0] + (ADDR_W'(r_grant) << PAGE_SHIFT)
                            : '0;
                    end
                end
                default: ;
            endcase
        end
    end
endmodule
`default_nettype wire

// ----- tb/tb_per_core_page_allocator.sv -----
// Self-checking testbench for per_core_page_allocator: random frees and allocates
// over several region/core settings, checked against a built-in list model.
// Depends on pcpa_pkg and the allocator RTL.
`default_nettype none
module tb_per_core_page_allocator;
    import pcpa_pkg::*;
    timeunit 1ns;
    timeprecision 1ps;

    typedef struct packed {
        logic        op;
        logic [5:0]  core;
        logic [33:0] addr;
    } t_req;

    typedef struct packed {
        logic [33:0] granted;
        logic [1:0]  status;
    } t_grant;

    localparam int STALL_LIMIT = 20000;

    logic         i_clk = 1'b0;
    logic         i_rst_n = 1'b0;
    logic         i_cfg_wen = 1'b0;
    logic [1:0]   i_cfg_addr = '0;
    logic [34:0]  i_cfg_wdata = '0;
    logic         s_axis_tvalid = 1'b0;
    logic         s_axis_tready;
    logic [39:0]  s_axis_tdata = '0;
    logic         s_axis_tuser = 1'b0;
    logic         m_axis_tvalid;
    logic         m_axis_tready = 1'b0;
    logic [39:0]  m_axis_tdata;
    logic [1:0]   m_axis_tuser;

    per_core_page_allocator dut (.*);

    always begin
        #10 i_clk = 1'b1;
        #10 i_clk = 1'b0;
    end

    // allocator shadow: links, heads, counts and registers
    logic [14:0] link_mem [PAGE_COUNT];
    logic        held_free [PAGE_COUNT];
    logic [14:0] head_idx [NUM_CORES];
    int unsigned page_cnt [NUM_CORES];
    logic [5:0]  sh_highest;
    logic [33:0] sh_start;
    logic [34:0] sh_end;

    t_req   req_q [$];
    t_grant grant_q [$];
    int     errors = 0;
    int     n_sent = 0;
    int     n_steals = 0;
    int     n_empty = 0;
    int     n_settings = 0;
    bit     no_idle = 0;

    function automatic logic [35:0] region_base();
        return ({2'b0, sh_start} + 36'd4095) & ~36'd4095;
    endfunction

    function automatic logic [33:0] page_to_addr(logic [14:0] idx);
        logic [35:0] a;
        a = region_base() + ({21'b0, idx} << PAGE_SHIFT);
        return a[33:0];
    endfunction

    // legal free target? returns page index through idx
    function automatic bit free_target(logic [5:0] core, logic [33:0] addr,
                                       output logic [14:0] idx);
        logic [35:0] rel;
        idx = '0;
        if (core >= NUM_CORES || addr[11:0] != 0) return 0;
        if (addr < sh_start || {1'b0, addr} >= sh_end) return 0;
        if ({2'b0, addr} < region_base()) return 0;
        rel = ({2'b0, addr} - region_base()) >> PAGE_SHIFT;
        if (rel >= PAGE_COUNT) return 0;
        idx = rel[14:0];
        return 1;
    endfunction

    function automatic t_grant alloc_page(logic [5:0] c);
        t_grant g;
        int unsigned lim, n;
        logic [14:0] r, tail;
        g = '{granted: '0, status: STAT_EMPTY};
        if (c >= NUM_CORES) return g;
        if (page_cnt[c] != 0) begin
            r = head_idx[c];
            head_idx[c] = link_mem[r];
            page_cnt[c]--;
            held_free[r] = 0;
            return '{granted: page_to_addr(r), status: STAT_ALLOC};
        end
        lim = (sh_highest > NUM_CORES - 1) ? NUM_CORES - 1 : sh_highest;
        for (int i = 0; i <= lim; i++) begin
            if (i == c || page_cnt[i] == 0) continue;
            n = page_cnt[i] / (sh_highest + 1);
            if (n == 0) n = 1;
            r = head_idx[i];
            tail = r;
            for (int k = 1; k < n; k++) tail = link_mem[tail];
            head_idx[i] = link_mem[tail];
            page_cnt[i] -= n;
            if (n > 1) begin
                head_idx[c] = link_mem[r];
                page_cnt[c] = n - 1;
            end
            held_free[r] = 0;
            n_steals++;
            return '{granted: page_to_addr(r), status: STAT_ALLOC};
        end
        return g;
    endfunction

    // queue one request and its predicted grant; a double free turns into an allocate
    task automatic send_req(logic op, logic [5:0] core, logic [33:0] addr);
        t_grant g;
        logic [14:0] idx;
        bit ok;
        ok = free_target(core, addr, idx);
        if (op == OP_FREE && ok && held_free[idx]) op = OP_ALLOC;
        if (op == OP_FREE) begin
            g = '{granted: '0, status: STAT_BAD};
            if (ok) begin
                link_mem[idx] = head_idx[core];
                head_idx[core] = idx;
                page_cnt[core]++;
                held_free[idx] = 1;
                g.status = STAT_FREED;
            end
        end else begin
            g = alloc_page(core);
        end
        if (g.status == STAT_EMPTY) n_empty++;
        req_q.push_back('{op: op, core: core, addr: addr});
        grant_q.push_back(g);
        n_sent++;
    endtask

    task automatic wait_idle();
        wait (req_q.size() == 0 && !s_axis_tvalid && grant_q.size() == 0);
        repeat (8) @(posedge i_clk);
    endtask

    task automatic write_reg(logic [1:0] ridx, logic [34:0] val);
        @(posedge i_clk);
        i_cfg_wen   <= 1'b1;
        i_cfg_addr  <= ridx;
        i_cfg_wdata <= val;
        if (ridx == REG_HIGHEST_CORE) sh_highest = val[5:0];
        else if (ridx == REG_REGION_START) sh_start = val[33:0];
        else sh_end = val;
    endtask

    task automatic set_region(logic [5:0] hc, logic [33:0] rs, logic [34:0] re);
        write_reg(REG_HIGHEST_CORE, {29'b0, hc});
        write_reg(REG_REGION_START, {1'b0, rs});
        write_reg(REG_REGION_END, re);
        @(posedge i_clk);
        i_cfg_wen <= 1'b0;
        n_settings++;
    endtask

    function automatic int gap_len();
        if (no_idle || $urandom_range(0, 9) < 6) return 0;
        if ($urandom_range(0, 9) < 8) return $urandom_range(1, 3);
        return $urandom_range(10, 40);
    endfunction

    // mostly legal frees and local allocates, with raw noise mixed in
    task automatic random_phase(int count);
        longint span;
        int pool;
        logic [14:0] idx;
        span = (longint'(sh_end) - longint'(region_base())) >>> PAGE_SHIFT;
        pool = (span <= 0) ? 0 : (span > PAGE_COUNT ? PAGE_COUNT : int'(span));
        for (int i = 0; i < count; i++) begin
            case ($urandom_range(0, 19))
                0, 1, 2: send_req(1'($urandom_range(0, 1)), 6'($urandom_range(0, 63)),
                                  34'({$urandom, $urandom}));
                3, 4, 5, 6, 7, 8, 9, 10, 11: begin
                    if (pool == 0) idx = '0;
                    else if ($urandom_range(0, 19) == 0)
                        idx = 15'($urandom_range(0, pool - 1));
                    else idx = 15'($urandom_range(0, (pool > 300 ? 300 : pool) - 1));
                    send_req(OP_FREE, 6'($urandom_range(0, NUM_CORES - 1)),
                             page_to_addr(idx));
                end
                default: send_req(OP_ALLOC, 6'($urandom_range(0, NUM_CORES - 1)),
                                  34'({$urandom, $urandom}));
            endcase
        end
        wait_idle();
    endtask

    // request driver
    int drv_gap = 0;
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            s_axis_tvalid <= 1'b0;
        end else if (!s_axis_tvalid || s_axis_tready) begin
            if (drv_gap > 0) begin
                drv_gap <= drv_gap - 1;
                s_axis_tvalid <= 1'b0;
            end else if (req_q.size() != 0) begin
                s_axis_tdata  <= {req_q[0].addr, req_q[0].core};
                s_axis_tuser  <= req_q[0].op;
                s_axis_tvalid <= 1'b1;
                void'(req_q.pop_front());
                drv_gap <= gap_len();
            end else begin
                s_axis_tvalid <= 1'b0;
            end
        end
    end

    // grant monitor with random back-pressure
    int mon_gap = 0;
    always @(posedge i_clk) begin
        t_grant exp_g;
        if (!i_rst_n) begin
            m_axis_tready <= 1'b0;
        end else begin
            if (m_axis_tvalid && m_axis_tready) begin
                if (grant_q.size() == 0) begin
                    $error("unexpected transfer: granted_address %h status %0d",
                           m_axis_tdata[33:0], m_axis_tuser);
                    errors++;
                end else begin
                    exp_g = grant_q.pop_front();
                    if (m_axis_tdata[33:0] !== exp_g.granted) begin
                        $error("granted_address: expected %h, got %h",
                               exp_g.granted, m_axis_tdata[33:0]);
                        errors++;
                    end
                    if (m_axis_tuser !== exp_g.status) begin
                        $error("status: expected %0d, got %0d", exp_g.status, m_axis_tuser);
                        errors++;
                    end
                end
            end
            if (mon_gap > 0) begin
                mon_gap <= mon_gap - 1;
                m_axis_tready <= 1'b0;
            end else begin
                m_axis_tready <= 1'b1;
                mon_gap <= gap_len();
            end
        end
    end

    // watchdog on cycles without any transfer
    int quiet = 0;
    always @(posedge i_clk) begin
        if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready)) begin
            quiet <= 0;
        end else if (quiet >= STALL_LIMIT) begin
            $display("Testbench completed WITH ERRORS");
            $finish;
        end else begin
            quiet <= quiet + 1;
        end
    end

    initial begin
        for (int i = 0; i < PAGE_COUNT; i++) begin
            link_mem[i] = '0;
            held_free[i] = 0;
        end
        for (int i = 0; i < NUM_CORES; i++) begin
            head_idx[i] = '0;
            page_cnt[i] = 0;
        end
        sh_highest = '0;
        sh_start = '0;
        sh_end = '0;
        repeat (3) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // empty region after reset: frees rejected, allocates find nothing
        send_req(OP_FREE, 0, 34'h0);
        send_req(OP_ALLOC, 0, 34'h0);
        wait_idle();

        set_region(7, 34'h0, 35'h4_0000_0000);
        send_req(OP_FREE, 0, 34'h0);
        send_req(OP_FREE, 0, 34'h0000_1000);
        send_req(OP_FREE, 0, 34'h0000_2000);
        send_req(OP_FREE, 7, 34'h0_07FF_F000);          // last page index
        send_req(OP_FREE, 7, 34'h0_0800_0000);          // index past the page count
        send_req(OP_FREE, 1, 34'h0000_3004);            // unaligned
        send_req(OP_FREE, 8, 34'h0000_4000);            // core out of range
        send_req(OP_FREE, 63, 34'h0000_5000);
        send_req(OP_ALLOC, 63, 34'h3_FFFF_FFFF);
        send_req(OP_ALLOC, 7, 34'h0);                   // local pop
        send_req(OP_ALLOC, 3, 34'h0);                   // steal from core 0
        send_req(OP_ALLOC, 3, 34'h0);
        send_req(OP_ALLOC, 3, 34'h0);
        send_req(OP_ALLOC, 5, 34'h0);                   // out of pages
        wait_idle();

        // bounds: start unaligned, end exclusive
        set_region(0, 34'h0_0000_1001, 35'h0_0000_9000);
        send_req(OP_FREE, 0, 34'h0_0000_1000);          // below start
        send_req(OP_FREE, 0, 34'h0_0000_2000);
        send_req(OP_FREE, 0, 34'h0_0000_8000);
        send_req(OP_FREE, 0, 34'h0_0000_9000);          // at end
        send_req(OP_ALLOC, 4, 34'h0);                   // steal whole list
        send_req(OP_ALLOC, 4, 34'h0);
        wait_idle();

        random_phase(80);
        no_idle = 1;
        set_region(63, 34'h3_FFFF_0000, 35'h4_0000_0000);
        random_phase(60);
        no_idle = 0;
        set_region(3, 34'h1_2345_6789, 35'h1_2400_0000);
        random_phase(80);
        set_region(7, 34'h3_FFFF_FFFF, 35'h7_FFFF_FFFF); // all frees below base
        random_phase(30);
        set_region(1, 34'h0, 35'h0_0010_0000);
        random_phase(80);
        set_region(5, 34'h0_8000_0000, 35'h0_8800_0000);
        random_phase(80);

        repeat (50) @(posedge i_clk);
        $display("Sent %0d requests over %0d register settings.", n_sent, n_settings);
        $display("Grants by stealing: %0d, out-of-pages replies: %0d.", n_steals, n_empty);
        if (errors == 0 && grant_q.size() == 0) begin
            $display("Testbench completed without errors");
        end else begin
            $display("Testbench completed WITH ERRORS");
        end
        $finish;
    end
endmodule
`default_nettype wire
